/* rtl/core/tic_pkg.sv */
package tic_pkg;

  // Depth of the status delay line
  localparam int STATUS_DELAY = 4;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  // Interrupt controller registers
  localparam logic [31:0] ADDR_VECTOR       = 32'hf000_0000;
  localparam logic [31:0] ADDR_TOP_CAUSE    = 32'hf000_0010;
  localparam logic [31:0] ADDR_MASK         = 32'hf000_0020;
  localparam logic [31:0] ADDR_STATUS       = 32'hf000_0030;
  localparam logic [31:0] ADDR_EPC          = 32'hf000_0040;
  localparam logic [31:0] ADDR_SYS_CAUSE    = 32'he100_0400;

  // Timer registers
  localparam logic [31:0] ADDR_TMR_CAUSE    = 32'he102_0400;
  localparam logic [31:0] ADDR_TMR_INV      = 32'he102_0800;
  localparam logic [31:0] ADDR_TMR_MASK     = 32'he102_0c00;
  localparam logic [31:0] ADDR_FREE_CNT     = 32'he102_4000;
  localparam logic [31:0] ADDR_PRESC_CNT    = 32'he102_4400;
  localparam logic [31:0] ADDR_PRESC_SEL    = 32'he102_4410;
  localparam logic [31:0] ADDR_CMP_CLEAR    = 32'he102_4420;
  localparam logic [31:0] ADDR_OUT_CMP      = 32'he102_4430;

  // Serial port cause registers
  localparam logic [31:0] ADDR_UART_INV     = 32'he103_0800;
  localparam logic [31:0] ADDR_UART_MASK    = 32'he103_0c00;

  // GPIO register addresses, in register order
  localparam int GPIO_REGS = 8;
  localparam logic [31:0] GPIO_ADDR [GPIO_REGS] = '{
    32'he101_0400, 32'he101_0800, 32'he101_0c00, 32'he101_4000,
    32'he101_4010, 32'he101_4020, 32'he101_4030, 32'he101_4040
  };

  // One bus or tick action, valid for the cycle it is executed
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic        tick;
    logic [31:0] addr;
    logic [31:0] wdata;
  } bus_req_t;

endpackage

/* rtl/core/timer_interrupt_controller.sv */
// Timer and interrupt controller. Each input beat is a bus read, a bus write
// or one processor clock tick (kind on s_axis_tuser); each produces exactly one
// output beat, in order. An item is captured in the input register and is
// executed as it moves into the output register. One item is accepted
// every cycle while the output side keeps taking beats; the output register
// holds a finished beat while the next item waits in the input register.
module timer_interrupt_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // addr[31:0], wdata[63:32], return_addr[95:64]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // rdata[31:0], irq_taken[32], jump_target[64:33],
                                     // cause_line[65], zero[71:66]
);
  import tic_pkg::*;

  // Input register
  logic        in_valid;
  logic [1:0]  in_op;
  logic [31:0] in_addr;
  logic [31:0] in_wdata;
  logic [31:0] in_ret;

  // Output register
  logic        out_valid;
  logic [71:0] out_data;

  // Controller state
  logic [31:0] vector_reg;
  logic [31:0] mask_reg;
  logic [31:0] status_reg;
  logic [31:0] status_delay [STATUS_DELAY];
  logic [31:0] epc_reg;
  logic [7:0]  gpio_regs [GPIO_REGS];
  logic [7:0]  uart_cause_invert;
  logic [7:0]  uart_cause_mask;

  logic        advance;
  bus_req_t    req;
  logic [31:0] timer_rdata;
  logic        top_cause;
  logic        top_cause_next;
  logic [31:0] rdata;
  logic        taken;
  logic        status_wr;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Decode the item in the input register
  always_comb begin
    req       = '0;
    req.addr  = in_addr;
    req.wdata = in_wdata;
    case (op_t'(in_op))
      OP_READ:  req.rd   = advance;
      OP_WRITE: req.wr   = advance;
      OP_TICK:  req.tick = advance;
      default:  ;
    endcase
  end

  tic_timer u_timer (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .rdata          (timer_rdata),
    .top_cause      (top_cause),
    .top_cause_next (top_cause_next)
  );

  // Interrupt entry on a tick
  assign taken     = req.tick && (status_delay[0] != 32'd0) && top_cause_next && mask_reg[0];
  assign status_wr = req.wr && (req.addr == ADDR_STATUS);

  // Read mux for the controller registers, merged with the timer side
  always_comb begin
    rdata = timer_rdata;
    if (req.rd) begin
      for (int i = 0; i < GPIO_REGS; i++) begin
        if (req.addr == GPIO_ADDR[i]) rdata = {24'd0, gpio_regs[i]};
      end
      case (req.addr)
        ADDR_VECTOR:    rdata = vector_reg;
        ADDR_MASK:      rdata = mask_reg;
        ADDR_STATUS:    rdata = status_reg;
        ADDR_EPC:       rdata = epc_reg;
        ADDR_UART_INV:  rdata = {24'd0, uart_cause_invert};
        ADDR_UART_MASK: rdata = {24'd0, uart_cause_mask};
        default:        ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_op    <= s_axis_tuser;
      in_addr  <= s_axis_tdata[31:0];
      in_wdata <= s_axis_tdata[63:32];
      in_ret   <= s_axis_tdata[95:64];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= {6'd0,
                   req.tick ? top_cause_next : top_cause,
                   taken ? vector_reg : 32'd0,
                   taken,
                   rdata};
    end
  end

  // Bus-written registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_reg        <= '0;
      mask_reg          <= '0;
      uart_cause_invert <= '0;
      uart_cause_mask   <= '0;
      for (int i = 0; i < GPIO_REGS; i++) gpio_regs[i] <= '0;
    end else if (req.wr) begin
      for (int i = 0; i < GPIO_REGS; i++) begin
        if (req.addr == GPIO_ADDR[i]) gpio_regs[i] <= req.wdata[7:0];
      end
      case (req.addr)
        ADDR_VECTOR:    vector_reg        <= req.wdata;
        ADDR_MASK:      mask_reg          <= req.wdata;
        ADDR_UART_INV:  uart_cause_invert <= req.wdata[7:0];
        ADDR_UART_MASK: uart_cause_mask   <= req.wdata[7:0];
        default:        ;
      endcase
    end
  end

  // Exception pc: bus write or return address on interrupt entry
  always_ff @(posedge clk) begin
    if (rst) begin
      epc_reg <= '0;
    end else if (taken) begin
      epc_reg <= in_ret;
    end else if (req.wr && req.addr == ADDR_EPC) begin
      epc_reg <= req.wdata;
    end
  end

  // Status register and its delay line
  always_ff @(posedge clk) begin
    if (rst) begin
      status_reg <= '0;
      for (int i = 0; i < STATUS_DELAY; i++) status_delay[i] <= '0;
    end else if (taken || (status_wr && req.wdata == 32'd0)) begin
      status_reg <= '0;
      for (int i = 0; i < STATUS_DELAY; i++) status_delay[i] <= '0;
    end else if (status_wr) begin
      status_delay[STATUS_DELAY-1] <= req.wdata;
    end else if (req.tick) begin
      // last entry keeps its value while the line shifts down
      status_reg <= status_delay[0];
      for (int i = 0; i < STATUS_DELAY - 1; i++) status_delay[i] <= status_delay[i+1];
    end
  end

endmodule

/* rtl/core/tic_timer.sv */
module tic_timer (
  input  logic              clk,
  input  logic              rst,
  input  tic_pkg::bus_req_t req,
  output logic [31:0]       rdata,
  output logic              top_cause,
  output logic              top_cause_next
);
  import tic_pkg::*;

  logic [31:0] free_counter;
  logic [15:0] prescaled_counter;
  logic [15:0] prescale_select;
  logic [15:0] compare_clear;
  logic [15:0] output_compare;
  logic [3:0]  timer_cause;
  logic [7:0]  timer_cause_invert;
  logic [7:0]  timer_cause_mask;
  logic [2:0]  system_cause;

  logic        clear_hit;
  logic [15:0] presc_cleared;
  logic [3:0]  timer_cause_next;
  logic        sys_hit;
  logic [31:0] free_counter_next;
  logic [14:0] one_shifted;
  logic [13:0] low_mask;
  logic        presc_step;
  logic [15:0] prescaled_counter_next;

  // Cause bits seen on a tick
  always_comb begin
    clear_hit        = (prescaled_counter == compare_clear);
    presc_cleared    = clear_hit ? 16'd0 : prescaled_counter;
    timer_cause_next = {(presc_cleared < output_compare),
                        timer_cause[2] ^ clear_hit,
                        free_counter[18],
                        free_counter[16]};
    sys_hit          = |(({4'd0, timer_cause_next} ^ timer_cause_invert) & timer_cause_mask);
    top_cause_next   = sys_hit;
  end

  // Counter advance; select 1..7 divides by 4^select
  always_comb begin
    free_counter_next = free_counter + 32'd1;
    one_shifted       = 15'd1 << {prescale_select[2:0], 1'b0};
    low_mask          = 14'(one_shifted - 15'd1);
    if (prescale_select >= 16'd1 && prescale_select <= 16'd7) begin
      presc_step = ((free_counter_next[13:0] & low_mask) == 14'd0);
    end else begin
      presc_step = 1'b1;
    end
    prescaled_counter_next = presc_cleared + {15'd0, presc_step};
  end

  // Register read mux
  always_comb begin
    rdata = 32'd0;
    if (req.rd) begin
      case (req.addr)
        ADDR_TOP_CAUSE: rdata = {31'd0, top_cause};
        ADDR_SYS_CAUSE: rdata = {29'd0, system_cause};
        ADDR_TMR_CAUSE: rdata = {28'd0, timer_cause};
        ADDR_TMR_INV:   rdata = {24'd0, timer_cause_invert};
        ADDR_TMR_MASK:  rdata = {24'd0, timer_cause_mask};
        ADDR_FREE_CNT:  rdata = free_counter;
        ADDR_PRESC_CNT: rdata = {16'd0, prescaled_counter};
        ADDR_PRESC_SEL: rdata = {16'd0, prescale_select};
        ADDR_CMP_CLEAR: rdata = {16'd0, compare_clear};
        ADDR_OUT_CMP:   rdata = {16'd0, output_compare};
        default:        rdata = 32'd0;
      endcase
    end
  end

  // Timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_counter       <= '0;
      prescaled_counter  <= '0;
      prescale_select    <= '0;
      compare_clear      <= '0;
      output_compare     <= '0;
      timer_cause        <= '0;
      timer_cause_invert <= '0;
      timer_cause_mask   <= '0;
      system_cause       <= '0;
      top_cause          <= 1'b0;
    end else if (req.tick) begin
      free_counter      <= free_counter_next;
      prescaled_counter <= prescaled_counter_next;
      timer_cause       <= timer_cause_next;
      system_cause      <= sys_hit ? 3'b100 : 3'b000;
      top_cause         <= sys_hit;
    end else if (req.wr) begin
      case (req.addr)
        ADDR_TMR_INV:   timer_cause_invert <= req.wdata[7:0];
        ADDR_TMR_MASK:  timer_cause_mask   <= req.wdata[7:0];
        ADDR_PRESC_CNT: prescaled_counter  <= req.wdata[15:0];
        ADDR_PRESC_SEL: prescale_select    <= req.wdata[15:0];
        ADDR_CMP_CLEAR: compare_clear      <= req.wdata[15:0];
        ADDR_OUT_CMP:   output_compare     <= req.wdata[15:0];
        default:        ;
      endcase
    end
  end

endmodule

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tic_pkg::*;

  // Item kind with no action, outside the package enum
  localparam logic [1:0] OP_NONE = 2'd3;

  // Serial port addresses that read as zero and ignore writes
  localparam logic [31:0] ADDR_UART_CAUSE = 32'he103_0400;
  localparam logic [31:0] ADDR_UART_DATA  = 32'he103_4000;
  localparam logic [31:0] ADDR_UART_DIV   = 32'he103_4010;

  // System cause value raised by the timer group
  localparam logic [2:0] SYS_CAUSE_TIMER = 3'b100;

  localparam int N_ITEMS      = 600;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_WAIT     = 16;
  localparam int N_REGS       = 27;

  // Every decoded address, read-only ones included, plus the undecoded serial port ones
  localparam logic [31:0] REG_ADDRS [N_REGS] = '{
    ADDR_VECTOR, ADDR_TOP_CAUSE, ADDR_MASK, ADDR_STATUS, ADDR_EPC, ADDR_SYS_CAUSE,
    ADDR_TMR_CAUSE, ADDR_TMR_INV, ADDR_TMR_MASK, ADDR_FREE_CNT, ADDR_PRESC_CNT,
    ADDR_PRESC_SEL, ADDR_CMP_CLEAR, ADDR_OUT_CMP, ADDR_UART_INV, ADDR_UART_MASK,
    ADDR_UART_CAUSE, ADDR_UART_DATA, ADDR_UART_DIV,
    GPIO_ADDR[0], GPIO_ADDR[1], GPIO_ADDR[2], GPIO_ADDR[3],
    GPIO_ADDR[4], GPIO_ADDR[5], GPIO_ADDR[6], GPIO_ADDR[7]
  };

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [31:0] ret;
  } bus_item_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
    logic [31:0] target;
    logic        cause;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;  // addr[31:0], wdata[63:32], return_addr[95:64]
  logic [1:0]  s_axis_tuser = '0;  // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;       // rdata[31:0], irq_taken[32], jump_target[64:33],
                                   // cause_line[65]

  timer_interrupt_controller dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // Shadow copy of the controller state
  logic [31:0] sh_vector = '0;
  logic [31:0] sh_mask = '0;
  logic [31:0] sh_status = '0;
  logic [31:0] sh_epc = '0;
  logic [31:0] sh_stat_pipe [STATUS_DELAY] = '{default: '0};
  logic        sh_top = 1'b0;
  logic [2:0]  sh_sys = '0;
  logic [7:0]  sh_gpio [GPIO_REGS] = '{default: '0};
  logic [3:0]  sh_tcause = '0;
  logic [7:0]  sh_tinv = '0;
  logic [7:0]  sh_tmask = '0;
  logic [31:0] sh_free = '0;
  logic [15:0] sh_pcnt = '0;
  logic [15:0] sh_psel = '0;
  logic [15:0] sh_cclr = '0;
  logic [15:0] sh_ocmp = '0;
  logic [7:0]  sh_uinv = '0;
  logic [7:0]  sh_umask = '0;

  bus_item_t bus_items[$];
  beat_t     due_beats[$];

  int  total_items, n_reads, n_writes, n_ticks, n_other;
  int  n_in, n_out, n_irq, mismatches, cycles;
  int  src_gap, src_calm, snk_stall, snk_calm;
  logic in_beat_done = 1'b0;
  logic out_beat_done = 1'b0;

  function automatic void drop_status();
    sh_status = '0;
    for (int i = 0; i < STATUS_DELAY; i++) sh_stat_pipe[i] = '0;
  endfunction

  function automatic logic [31:0] reg_read(logic [31:0] a);
    logic [31:0] v;
    v = '0;
    case (a)
      ADDR_VECTOR:    v = sh_vector;
      ADDR_TOP_CAUSE: v = {31'd0, sh_top};
      ADDR_MASK:      v = sh_mask;
      ADDR_STATUS:    v = sh_status;
      ADDR_EPC:       v = sh_epc;
      ADDR_SYS_CAUSE: v = {29'd0, sh_sys};
      ADDR_TMR_CAUSE: v = {28'd0, sh_tcause};
      ADDR_TMR_INV:   v = {24'd0, sh_tinv};
      ADDR_TMR_MASK:  v = {24'd0, sh_tmask};
      ADDR_FREE_CNT:  v = sh_free;
      ADDR_PRESC_CNT: v = {16'd0, sh_pcnt};
      ADDR_PRESC_SEL: v = {16'd0, sh_psel};
      ADDR_CMP_CLEAR: v = {16'd0, sh_cclr};
      ADDR_OUT_CMP:   v = {16'd0, sh_ocmp};
      ADDR_UART_INV:  v = {24'd0, sh_uinv};
      ADDR_UART_MASK: v = {24'd0, sh_umask};
      default: begin
        for (int i = 0; i < GPIO_REGS; i++)
          if (a == GPIO_ADDR[i]) v = {24'd0, sh_gpio[i]};
      end
    endcase
    return v;
  endfunction

  function automatic void reg_write(logic [31:0] a, logic [31:0] v);
    case (a)
      ADDR_VECTOR:    sh_vector = v;
      ADDR_MASK:      sh_mask = v;
      ADDR_EPC:       sh_epc = v;
      // zero clears, anything else enters the tail of the delay line
      ADDR_STATUS: begin
        if (v == 0) drop_status();
        else sh_stat_pipe[STATUS_DELAY - 1] = v;
      end
      ADDR_TMR_INV:   sh_tinv = v[7:0];
      ADDR_TMR_MASK:  sh_tmask = v[7:0];
      ADDR_PRESC_CNT: sh_pcnt = v[15:0];
      ADDR_PRESC_SEL: sh_psel = v[15:0];
      ADDR_CMP_CLEAR: sh_cclr = v[15:0];
      ADDR_OUT_CMP:   sh_ocmp = v[15:0];
      ADDR_UART_INV:  sh_uinv = v[7:0];
      ADDR_UART_MASK: sh_umask = v[7:0];
      default: begin
        for (int i = 0; i < GPIO_REGS; i++)
          if (a == GPIO_ADDR[i]) sh_gpio[i] = v[7:0];
      end
    endcase
  endfunction

  // One processor clock: returns 1 when the interrupt is entered
  function automatic logic timer_tick(logic [31:0] ret);
    logic [31:0] step_mask;
    sh_status = sh_stat_pipe[0];
    for (int i = 0; i < STATUS_DELAY - 1; i++) sh_stat_pipe[i] = sh_stat_pipe[i + 1];
    // timer cause: free counter taps, compare toggle, output compare
    sh_tcause[0] = sh_free[16];
    sh_tcause[1] = sh_free[18];
    if (sh_pcnt == sh_cclr) begin
      sh_pcnt = '0;
      sh_tcause[2] = ~sh_tcause[2];
    end
    sh_tcause[3] = (sh_pcnt < sh_ocmp);
    sh_sys = ((({4'd0, sh_tcause} ^ sh_tinv) & sh_tmask) != 0) ? SYS_CAUSE_TIMER : 3'd0;
    sh_top = (sh_sys != 0);
    // counters advance; prescaler steps every tick unless select is one to seven
    sh_free = sh_free + 32'd1;
    if (sh_psel >= 1 && sh_psel <= 7) begin
      step_mask = (32'd1 << (2 * sh_psel)) - 32'd1;
      if ((sh_free & step_mask) == 0) sh_pcnt = sh_pcnt + 16'd1;
    end else begin
      sh_pcnt = sh_pcnt + 16'd1;
    end
    if (sh_status != 0 && sh_top && sh_mask[0]) begin
      sh_epc = ret;
      drop_status();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic beat_t controller_step(logic [1:0] op, logic [31:0] addr,
                                            logic [31:0] wdata, logic [31:0] ret);
    beat_t b;
    b = '0;
    case (op)
      OP_READ:  b.rdata = reg_read(addr);
      OP_WRITE: reg_write(addr, wdata);
      OP_TICK: begin
        b.irq = timer_tick(ret);
        if (b.irq) b.target = sh_vector;
      end
      default: ;
    endcase
    b.cause = sh_top;
    return b;
  endfunction

  // Wait before an item or a beat; now and then a stretch with no waits
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_bad(string what, beat_t want, beat_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: exp rdata=%h irq=%b target=%h cause=%b, ",
                "got rdata=%h irq=%b target=%h cause=%b"},
               $realtime, what, want.rdata, want.irq, want.target, want.cause,
               seen.rdata, seen.irq, seen.target, seen.cause);
  endtask

  // Stimulus building
  task automatic add_item(logic [1:0] op, logic [31:0] addr, logic [31:0] wdata,
                          logic [31:0] ret);
    bus_items.push_back('{op: op, addr: addr, wdata: wdata, ret: ret});
    case (op)
      OP_READ:  n_reads++;
      OP_WRITE: n_writes++;
      OP_TICK:  n_ticks++;
      default:  n_other++;
    endcase
  endtask

  function automatic logic [31:0] pick_reg();
    return REG_ADDRS[$urandom_range(0, N_REGS - 1)];
  endfunction

  // Small values dominate so compare and prescale settings matter within the run
  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
      default: return $urandom_range(0, 24);
    endcase
  endfunction

  // Well-formed run: maybe arm a cause source, load status, then tick with reads mixed in
  task automatic add_scenario();
    int n;
    if ($urandom_range(0, 1)) begin
      add_item(OP_WRITE, ADDR_TMR_INV, $urandom(), $urandom());
      add_item(OP_WRITE, ADDR_TMR_MASK, $urandom_range(1, 255), $urandom());
    end
    if ($urandom_range(0, 2) == 0) begin
      add_item(OP_WRITE, ADDR_PRESC_SEL, $urandom_range(0, 9), $urandom());
      add_item(OP_WRITE, ADDR_CMP_CLEAR, $urandom_range(0, 12), $urandom());
      add_item(OP_WRITE, ADDR_OUT_CMP, $urandom_range(0, 12), $urandom());
    end
    repeat ($urandom_range(0, 2)) add_item(OP_WRITE, pick_reg(), pick_data(), $urandom());
    add_item(OP_WRITE, ADDR_MASK, ($urandom_range(0, 4) != 0) ? ($urandom() | 32'd1) : $urandom(),
             $urandom());
    if ($urandom_range(0, 1)) add_item(OP_WRITE, ADDR_VECTOR, $urandom(), $urandom());
    add_item(OP_WRITE, ADDR_STATUS, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom(), $urandom());
    n = $urandom_range(2, 10);
    repeat (n) begin
      add_item(OP_TICK, $urandom(), $urandom(), $urandom());
      if ($urandom_range(0, 2) == 0) add_item(OP_READ, pick_reg(), $urandom(), $urandom());
    end
  endtask

  task automatic add_noise();
    add_item(2'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0) ? $urandom() : pick_reg(),
             pick_data(), $urandom());
  endtask

  // Input driver
  always @(negedge clk) begin : drive_in
    bus_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_beat_done) begin
      if (src_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (bus_items.size() != 0) begin
        it = bus_items.pop_front();
        s_axis_tuser <= it.op;
        s_axis_tdata <= {it.ret, it.wdata, it.addr};
        s_axis_tvalid <= 1'b1;
        src_gap <= draw_wait(src_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output ready with random stalls
  always @(negedge clk) begin : drive_out
    int d;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tready) begin
      if (out_beat_done) begin
        d = draw_wait(snk_calm);
        if (d != 0) begin
          m_axis_tready <= 1'b0;
          snk_stall <= d - 1;
        end
      end
    end else if (snk_stall > 0) begin
      snk_stall <= snk_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: check output beats, predict on accepted input beats
  always @(posedge clk) begin : watch
    beat_t seen, want;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d of %0d items accepted", cycles, n_in, total_items);
      $display("** timer_interrupt_controller: FAILED **");
      $finish;
    end else if (rst) begin
      in_beat_done <= 1'b0;
      out_beat_done <= 1'b0;
    end else begin
      in_beat_done <= s_axis_tvalid && s_axis_tready;
      out_beat_done <= m_axis_tvalid && m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        seen = '{rdata: m_axis_tdata[31:0], irq: m_axis_tdata[32],
                 target: m_axis_tdata[64:33], cause: m_axis_tdata[65]};
        n_out++;
        if (due_beats.size() == 0) begin
          report_bad("unexpected beat", '0, seen);
        end else begin
          want = due_beats.pop_front();
          if (seen != want) report_bad("mismatch", want, seen);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = controller_step(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                               s_axis_tdata[95:64]);
        if (want.irq) n_irq++;
        due_beats.push_back(want);
        n_in++;
      end
    end
  end

  initial begin
    // directed: reset values, extremes, no-op kind, unmapped access, status clear,
    // interrupt entry, prescale select outside one to seven
    add_item(OP_READ, ADDR_VECTOR, '0, '0);
    add_item(OP_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_item(OP_WRITE, ADDR_VECTOR, 32'hffff_ffff, '0);
    add_item(OP_WRITE, ADDR_MASK, 32'hffff_ffff, '0);
    add_item(OP_WRITE, ADDR_TMR_INV, 32'hffff_ffff, '0);
    add_item(OP_WRITE, ADDR_TMR_MASK, 32'h0000_0001, '0);
    add_item(OP_WRITE, GPIO_ADDR[7], 32'hffff_ffff, '0);
    add_item(OP_READ, GPIO_ADDR[7], '0, '0);
    add_item(OP_WRITE, ADDR_FREE_CNT, 32'hffff_ffff, '0);
    add_item(OP_WRITE, 32'hffff_ffff, 32'hffff_ffff, '0);
    add_item(OP_READ, 32'hffff_ffff, '0, '0);
    add_item(OP_WRITE, ADDR_STATUS, 32'hffff_ffff, '0);
    repeat (4) add_item(OP_TICK, '0, '0, 32'hffff_ffff);
    add_item(OP_READ, ADDR_EPC, '0, '0);
    add_item(OP_WRITE, ADDR_STATUS, 32'd5, '0);
    add_item(OP_WRITE, ADDR_STATUS, 32'd0, '0);
    add_item(OP_WRITE, ADDR_PRESC_SEL, 32'hffff_ffff, '0);
    add_item(OP_WRITE, ADDR_CMP_CLEAR, 32'd2, '0);
    add_item(OP_WRITE, ADDR_OUT_CMP, 32'd1, '0);
    repeat (4) add_item(OP_TICK, '0, '0, '0);
    add_item(OP_READ, ADDR_TMR_CAUSE, '0, '0);
    add_item(OP_READ, ADDR_PRESC_CNT, '0, '0);

    // random: mostly armed interrupt runs, the rest noise
    while (bus_items.size() < N_ITEMS) begin
      if ($urandom_range(0, 9) < 7) add_scenario();
      else repeat ($urandom_range(1, 6)) add_noise();
    end
    total_items = bus_items.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_in != total_items || due_beats.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("covered %0d items: %0d reads, %0d writes, %0d ticks, %0d no-op", total_items,
             n_reads, n_writes, n_ticks, n_other);
    $display("%0d result beats checked, %0d interrupt entries, %0d mismatches", n_out, n_irq,
             mismatches);
    if (mismatches == 0 && due_beats.size() == 0) begin
      $display("** timer_interrupt_controller: PASSED **");
    end else begin
      $display("** timer_interrupt_controller: FAILED **");
    end
    $finish;
  end

endmodule
